// ----- rtl/core/i2a_pkg.sv -----
// Shared types, constants and helpers of the integer-to-ASCII formatter.
package i2a_pkg;

   localparam int VALUE_BITS      = 32;
   localparam int RADIX_BITS      = 5;
   localparam int WIDTH_BITS      = 7;
   localparam int FLAG_BITS       = 5;
   localparam int CHAR_BITS       = 7;
   localparam int COUNT_BITS      = 7;
   localparam int DIGIT_BITS      = 4;

   localparam int DIGIT_SLOTS_DEF = 32;
   localparam int MAX_WIDTH_DEF   = 64;
   localparam int CHAR_LIMIT      = 64;

   // Long division: quotient bits retired per cycle and division steps per digit.
   localparam int BITS_PER_STEP   = 8;
   localparam int STEPS_PER_DIGIT = VALUE_BITS / BITS_PER_STEP;
   localparam int STEP_CNT_BITS   = $clog2(STEPS_PER_DIGIT);

   localparam int QUEUE_DEPTH     = 2;

   // Flag bit positions.
   localparam int FLAG_LEFT       = 0;
   localparam int FLAG_PLUS       = 1;
   localparam int FLAG_ZERO       = 2;
   localparam int FLAG_SIGNED     = 3;
   localparam int FLAG_CAPS       = 4;

   localparam logic [RADIX_BITS-1:0] RADIX_DEFAULT = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 5'd16;

   localparam logic [CHAR_BITS-1:0] ASCII_SPACE = 7'h20;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] ASCII_PLUS  = 7'h2B;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 7'h2D;
   localparam logic [CHAR_BITS-1:0] ASCII_UPPER = 7'h41;
   localparam logic [CHAR_BITS-1:0] ASCII_LOWER = 7'h61;

   typedef enum logic [1:0] {
      PAD_LEAD_SPACE,
      PAD_ZERO_FILL,
      PAD_TRAIL_SPACE
   } pad_mode_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      PHASE_LEAD,
      PHASE_SIGN,
      PHASE_ZERO,
      PHASE_DIGIT,
      PHASE_TRAIL
   } phase_type;

   // Classified number, handed from the front to the back (digits travel apart).
   typedef struct packed {
      logic [CHAR_BITS-1:0]  sign_char;
      logic                  has_sign;
      logic [COUNT_BITS-1:0] digit_count;
      logic [COUNT_BITS-1:0] pad_count;
      pad_mode_type          pad_mode;
      logic                  caps;
   } desc_type;

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                                       input logic caps);
      logic [CHAR_BITS-1:0] base;
      base = caps ? ASCII_UPPER : ASCII_LOWER;
      if (d < 4'd10) begin
         digit_char = ASCII_ZERO + CHAR_BITS'(d);
      end else begin
         digit_char = base + CHAR_BITS'(d - 4'd10);
      end
   endfunction

endpackage

// ----- rtl/core/i2a_queue.sv -----
// Short descriptor queue between the front and the back.
module i2a_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = i2a_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/i2a_front.sv -----
// Front end: accepts a number, classifies sign and padding, extracts the digits.
module i2a_front #(
   parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF,
   parameter int MAX_WIDTH   = i2a_pkg::MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [i2a_pkg::VALUE_BITS-1:0]        req_value,
   input  logic [i2a_pkg::RADIX_BITS-1:0]        req_radix,
   input  logic [i2a_pkg::WIDTH_BITS-1:0]        req_field_width,
   input  logic [i2a_pkg::FLAG_BITS-1:0]         req_format_flags,
   output logic                                  q_push,
   output i2a_pkg::desc_type                     q_desc,
   output logic [DIGIT_SLOTS*i2a_pkg::DIGIT_BITS-1:0] q_digits,
   input  logic                                  q_full
);

   localparam int VB = i2a_pkg::VALUE_BITS;
   localparam int DB = i2a_pkg::DIGIT_BITS;
   localparam int SB = DIGIT_SLOTS * DB;
   localparam int BP = i2a_pkg::BITS_PER_STEP;

   i2a_pkg::front_state_type state_ff, state_in;

   logic [VB-1:0]                        work_ff, work_in;
   logic [DB-1:0]                        rem_ff, rem_in;
   logic [i2a_pkg::RADIX_BITS-1:0]       radix_ff, radix_in;
   logic [i2a_pkg::STEP_CNT_BITS-1:0]    step_ff, step_in;
   logic [i2a_pkg::COUNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [SB-1:0]                        digits_ff, digits_in;
   logic [i2a_pkg::WIDTH_BITS-1:0]       width_ff, width_in;
   logic                                 has_sign_ff, has_sign_in;
   logic [i2a_pkg::CHAR_BITS-1:0]        sign_char_ff, sign_char_in;
   i2a_pkg::pad_mode_type                mode_ff, mode_in;
   logic                                 caps_ff, caps_in;

   logic [DB:0]                          rem_v;
   logic [BP-1:0]                        quot_v;
   logic                                 negative;
   logic [i2a_pkg::COUNT_BITS-1:0]       len;

   // One division cycle: retire BP quotient bits of the working word.
   always_comb begin
      rem_v  = {1'b0, rem_ff};
      quot_v = '0;
      for (int i = 0; i < BP; i++) begin
         rem_v = {rem_v[DB-1:0], work_ff[VB-1-i]};
         if (rem_v >= radix_ff) begin
            rem_v         = rem_v - radix_ff;
            quot_v[BP-1-i] = 1'b1;
         end
      end
   end

   assign len = cnt_ff + i2a_pkg::COUNT_BITS'(has_sign_ff);

   always_comb begin
      q_desc.sign_char   = sign_char_ff;
      q_desc.has_sign    = has_sign_ff;
      q_desc.digit_count = cnt_ff;
      q_desc.pad_count   = (width_ff > len) ? width_ff - len : '0;
      q_desc.pad_mode    = mode_ff;
      q_desc.caps        = caps_ff;
   end
   assign q_digits = digits_ff;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      digits_in    = digits_ff;
      width_in     = width_ff;
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      mode_in      = mode_ff;
      caps_in      = caps_ff;
      req_full     = 1'b1;
      q_push       = 1'b0;
      negative     = req_format_flags[i2a_pkg::FLAG_SIGNED] && req_value[VB-1];

      case (state_ff)
         i2a_pkg::FRONT_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               if (req_radix inside {[5'd0:5'd1]}) begin
                  radix_in = i2a_pkg::RADIX_DEFAULT;
               end else if (req_radix > i2a_pkg::RADIX_MAX) begin
                  radix_in = i2a_pkg::RADIX_MAX;
               end else begin
                  radix_in = req_radix;
               end
               width_in = (req_field_width > i2a_pkg::WIDTH_BITS'(MAX_WIDTH))
                          ? i2a_pkg::WIDTH_BITS'(MAX_WIDTH) : req_field_width;
               has_sign_in  = negative || req_format_flags[i2a_pkg::FLAG_PLUS];
               sign_char_in = negative ? i2a_pkg::ASCII_MINUS : i2a_pkg::ASCII_PLUS;
               work_in      = negative ? (VB'(0) - req_value) : req_value;
               if (req_format_flags[i2a_pkg::FLAG_LEFT]) begin
                  mode_in = i2a_pkg::PAD_TRAIL_SPACE;
               end else if (req_format_flags[i2a_pkg::FLAG_ZERO]) begin
                  mode_in = i2a_pkg::PAD_ZERO_FILL;
               end else begin
                  mode_in = i2a_pkg::PAD_LEAD_SPACE;
               end
               caps_in  = req_format_flags[i2a_pkg::FLAG_CAPS];
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = '0;
               state_in = i2a_pkg::FRONT_DIV;
            end
         end
         i2a_pkg::FRONT_DIV: begin
            work_in = {work_ff[VB-BP-1:0], quot_v};
            rem_in  = rem_v[DB-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == i2a_pkg::STEP_CNT_BITS'(i2a_pkg::STEPS_PER_DIGIT - 1)) begin
               // Remainder is the next digit; insert at the top, oldest slides down.
               digits_in = {rem_v[DB-1:0], digits_ff[SB-1:DB]};
               cnt_in    = cnt_ff + 1'b1;
               rem_in    = '0;
               if (work_in == '0 || cnt_in == i2a_pkg::COUNT_BITS'(DIGIT_SLOTS)) begin
                  state_in = i2a_pkg::FRONT_PUSH;
               end
            end
         end
         i2a_pkg::FRONT_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = i2a_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = i2a_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2a_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      radix_ff     <= radix_in;
      step_ff      <= step_in;
      cnt_ff       <= cnt_in;
      digits_ff    <= digits_in;
      width_ff     <= width_in;
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      mode_ff      <= mode_in;
      caps_ff      <= caps_in;
   end

endmodule

// ----- rtl/core/i2a_back.sv -----
// Back end: emits padding, sign and digits of a classified number, one character per beat.
module i2a_back #(
   parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   input  i2a_pkg::desc_type                     q_desc,
   input  logic [DIGIT_SLOTS*i2a_pkg::DIGIT_BITS-1:0] q_digits,
   output logic                                  q_pop,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [i2a_pkg::CHAR_BITS-1:0]         rsp_character,
   output logic                                  rsp_last,
   output logic [i2a_pkg::COUNT_BITS-1:0]        rsp_emitted_count
);

   localparam int DB = i2a_pkg::DIGIT_BITS;
   localparam int SB = DIGIT_SLOTS * DB;
   localparam int CB = i2a_pkg::COUNT_BITS;

   i2a_pkg::back_state_type state_ff, state_in;
   i2a_pkg::phase_type      phase;

   logic [CB-1:0]                 pad_ff, pad_in;
   logic [CB-1:0]                 dig_ff, dig_in;
   logic [CB-1:0]                 total_ff, total_in;
   logic [CB-1:0]                 count_ff, count_in;
   logic                          sign_ff, sign_in;
   logic [i2a_pkg::CHAR_BITS-1:0] sign_char_ff, sign_char_in;
   i2a_pkg::pad_mode_type         mode_ff, mode_in;
   logic                          caps_ff, caps_in;
   logic [SB-1:0]                 digits_ff, digits_in;

   logic                          out_valid_ff, out_valid_in;
   logic [i2a_pkg::CHAR_BITS-1:0] out_char_ff, out_char_in;
   logic                          out_last_ff, out_last_in;
   logic [CB-1:0]                 out_count_ff, out_count_in;
   logic                          advance;

   assign rsp_empty         = !out_valid_ff;
   assign rsp_character     = out_char_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_emitted_count = out_count_ff;
   assign advance           = !out_valid_ff || rsp_pop;

   // Pick what goes out next from what is left of each part of the field.
   always_comb begin
      if (mode_ff == i2a_pkg::PAD_LEAD_SPACE && pad_ff != '0) begin
         phase = i2a_pkg::PHASE_LEAD;
      end else if (sign_ff) begin
         phase = i2a_pkg::PHASE_SIGN;
      end else if (mode_ff == i2a_pkg::PAD_ZERO_FILL && pad_ff != '0) begin
         phase = i2a_pkg::PHASE_ZERO;
      end else if (dig_ff != '0) begin
         phase = i2a_pkg::PHASE_DIGIT;
      end else begin
         phase = i2a_pkg::PHASE_TRAIL;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      dig_in       = dig_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      sign_in      = sign_ff;
      sign_char_in = sign_char_ff;
      mode_in      = mode_ff;
      caps_in      = caps_ff;
      digits_in    = digits_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_count_in = out_count_ff;
      q_pop        = 1'b0;

      case (state_ff)
         i2a_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               pad_in       = q_desc.pad_count;
               dig_in       = q_desc.digit_count;
               sign_in      = q_desc.has_sign;
               sign_char_in = q_desc.sign_char;
               mode_in      = q_desc.pad_mode;
               caps_in      = q_desc.caps;
               digits_in    = q_digits;
               total_in     = q_desc.pad_count + q_desc.digit_count
                              + CB'(q_desc.has_sign);
               count_in     = '0;
               state_in     = i2a_pkg::BACK_EMIT;
            end
         end
         i2a_pkg::BACK_EMIT: begin
            if (advance) begin
               out_valid_in = 1'b1;
               count_in     = count_ff + 1'b1;
               out_count_in = count_in;
               out_last_in  = (count_in == total_ff);
               case (phase)
                  i2a_pkg::PHASE_LEAD,
                  i2a_pkg::PHASE_TRAIL: begin
                     out_char_in = i2a_pkg::ASCII_SPACE;
                     pad_in      = pad_ff - 1'b1;
                  end
                  i2a_pkg::PHASE_ZERO: begin
                     out_char_in = i2a_pkg::ASCII_ZERO;
                     pad_in      = pad_ff - 1'b1;
                  end
                  i2a_pkg::PHASE_SIGN: begin
                     out_char_in = sign_char_ff;
                     sign_in     = 1'b0;
                  end
                  i2a_pkg::PHASE_DIGIT: begin
                     out_char_in = i2a_pkg::digit_char(digits_ff[SB-1 -: DB], caps_ff);
                     dig_in      = dig_ff - 1'b1;
                     digits_in   = {digits_ff[SB-DB-1:0], DB'(0)};
                  end
                  default: begin
                     out_char_in = i2a_pkg::ASCII_SPACE;
                  end
               endcase
               if (out_last_in) begin
                  state_in = i2a_pkg::BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = i2a_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2a_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff       <= pad_in;
      dig_ff       <= dig_in;
      total_ff     <= total_in;
      count_ff     <= count_in;
      sign_ff      <= sign_in;
      sign_char_ff <= sign_char_in;
      mode_ff      <= mode_in;
      caps_ff      <= caps_in;
      digits_ff    <= digits_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_count_ff <= out_count_in;
   end

endmodule

// ----- rtl/core/integer_to_ascii_formatter.sv -----
// Top level of the integer-to-ASCII formatter: front, descriptor queue, back.
//
// Usage: push a 32-bit value with radix, field width and flags on the req_
// side while req_full is low. The formatted text comes out on the rsp_ side,
// one ASCII character per beat, most significant first, with rsp_last set on
// the final beat of a number and rsp_emitted_count counting beats from 1.
// The front divides the value by the radix with a shared long-division unit
// that retires 8 quotient bits per cycle; each digit is the remainder of one
// full division of the working value. The back fetches a descriptor and
// then emits one character per cycle while the receiver keeps popping. A
// two-entry queue lets the front extract the next number while the back is
// still emitting the previous one. The first character reaches the rsp_
// ports after the division steps, the push into the queue, the descriptor
// fetch and the output register. Reset empties the queue and the output
// register and returns both halves to idle. When the receiver holds off
// pop, the current character stays on the rsp_ ports, the back waits, and
// once the queue fills req_full stays high.
module integer_to_ascii_formatter #(
   parameter int DIGIT_SLOTS = i2a_pkg::DIGIT_SLOTS_DEF,
   parameter int MAX_WIDTH   = i2a_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [i2a_pkg::VALUE_BITS-1:0]     req_value,
   input  logic [i2a_pkg::RADIX_BITS-1:0]     req_radix,
   input  logic [i2a_pkg::WIDTH_BITS-1:0]     req_field_width,
   input  logic [i2a_pkg::FLAG_BITS-1:0]      req_format_flags,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [i2a_pkg::CHAR_BITS-1:0]      rsp_character,
   output logic                               rsp_last,
   output logic [i2a_pkg::COUNT_BITS-1:0]     rsp_emitted_count
);

   localparam int SB = DIGIT_SLOTS * i2a_pkg::DIGIT_BITS;
   localparam int DW = $bits(i2a_pkg::desc_type);

   logic              q_push, q_full, q_pop, q_empty;
   i2a_pkg::desc_type front_desc, back_desc;
   logic [SB-1:0]     front_digits, back_digits;
   logic [DW+SB-1:0]  q_out;

   i2a_front #(
      .DIGIT_SLOTS (DIGIT_SLOTS),
      .MAX_WIDTH   (MAX_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_value        (req_value),
      .req_radix        (req_radix),
      .req_field_width  (req_field_width),
      .req_format_flags (req_format_flags),
      .q_push           (q_push),
      .q_desc           (front_desc),
      .q_digits         (front_digits),
      .q_full           (q_full)
   );

   i2a_queue #(
      .WIDTH (DW + SB),
      .DEPTH (i2a_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({front_desc, front_digits}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign back_desc   = q_out[DW+SB-1:SB];
   assign back_digits = q_out[SB-1:0];

   i2a_back #(
      .DIGIT_SLOTS (DIGIT_SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_desc            (back_desc),
      .q_digits          (back_digits),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_character     (rsp_character),
      .rsp_last          (rsp_last),
      .rsp_emitted_count (rsp_emitted_count)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("front pushed into a full queue");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back took a descriptor from an empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_emitted_count != '0 &&
                      rsp_emitted_count <= i2a_pkg::COUNT_BITS'(i2a_pkg::CHAR_LIMIT)))
      else $error("character count out of range");

   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_last) ##1 !rsp_empty
         |-> rsp_emitted_count == i2a_pkg::COUNT_BITS'(1))
      else $error("new number did not restart the character count");

endmodule
